@@ rtl/core/lpr_pkg.sv @@
// Shared types, constants and codes for the LRU port reserver.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int SLOT_AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int STAMP_W   = 32;
    localparam int PORT_W    = 16;
    localparam int MASK_W    = 64;
    localparam int CNT_REG_W = 7;
    localparam int PADDR_W   = 3;

    localparam logic KIND_RESERVE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_EXHAUSTED = 1'b1;

    localparam logic REG_BASE_PORT  = 1'b0;
    localparam logic REG_SLOT_COUNT = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [STAMP_W-1:0]  now_time;
        logic [MASK_W-1:0]   local_free_mask;
        logic [MASK_W-1:0]   remote_free_mask;
        logic [PORT_W-1:0]   release_port;
    } lpr_req_t;

    typedef struct packed {
        logic [PORT_W-1:0] granted_port;
        logic              status;
    } lpr_resp_t;

    typedef struct packed {
        logic [PORT_W-1:0]    base_port;
        logic [CNT_REG_W-1:0] slot_count;
    } lpr_cfg_t;

    typedef struct packed {
        logic               rd_en;
        logic [SLOT_AW-1:0] rd_addr;
        logic               wr_en;
        logic [SLOT_AW-1:0] wr_addr;
        logic [STAMP_W-1:0] wr_data;
    } lpr_ram_req_t;

endpackage

`default_nettype wire

@@ rtl/core/lpr_stamp_ram.sv @@
// Slot timestamp store: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Uses lpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpr_stamp_ram (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire lpr_pkg::lpr_ram_req_t        req,
    output logic [lpr_pkg::STAMP_W-1:0]       rd_data
);

    logic [lpr_pkg::STAMP_W-1:0]   mem [lpr_pkg::MAX_SLOTS];
    logic [lpr_pkg::MAX_SLOTS-1:0] valid_reg;
    logic [lpr_pkg::STAMP_W-1:0]   rd_q_reg;
    logic                          rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_q_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_vld_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

`default_nettype wire

@@ rtl/core/lpr_scan_ctrl.sv @@
// Request sequencer: scans stamps through the RAM read port, commits the
// winner, handles releases and keeps the held-slot bitmap. Uses lpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpr_scan_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire lpr_pkg::lpr_cfg_t            cfg,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire lpr_pkg::lpr_req_t            s_data,
    output lpr_pkg::lpr_ram_req_t             ram_req,
    input  wire logic [lpr_pkg::STAMP_W-1:0]  ram_rd_data,
    output logic                              res_valid,
    output lpr_pkg::lpr_resp_t                res_data,
    input  wire logic                         res_ready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_REL,
        ST_FINISH
    } state_t;

    state_t                          state_reg, state_next;
    logic                            kind_reg, kind_next;
    logic [lpr_pkg::STAMP_W-1:0]     now_reg, now_next;
    logic [lpr_pkg::MASK_W-1:0]      both_reg, both_next;
    logic [lpr_pkg::PORT_W-1:0]      rel_reg, rel_next;
    logic [lpr_pkg::CNT_W-1:0]       n_reg, n_next;
    logic [lpr_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            cmp_valid_reg, cmp_valid_next;
    logic [lpr_pkg::SLOT_AW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                            found_reg, found_next;
    logic [lpr_pkg::SLOT_AW-1:0]     best_reg, best_next;
    logic [lpr_pkg::STAMP_W-1:0]     best_stamp_reg, best_stamp_next;
    logic [lpr_pkg::MAX_SLOTS-1:0]   held_reg, held_next;
    lpr_pkg::lpr_resp_t              res_reg, res_next;

    logic [lpr_pkg::CNT_W-1:0]       n_sat;
    logic [lpr_pkg::PORT_W-1:0]      rel_idx;
    logic                            rel_hit;
    logic                            take;

    always_comb begin
        if (cfg.slot_count > lpr_pkg::CNT_REG_W'(lpr_pkg::MAX_SLOTS)) begin
            n_sat = lpr_pkg::CNT_W'(lpr_pkg::MAX_SLOTS);
        end else begin
            n_sat = lpr_pkg::CNT_W'(cfg.slot_count);
        end
    end

    assign rel_idx = rel_reg - cfg.base_port;
    assign rel_hit = (rel_idx < lpr_pkg::PORT_W'(n_reg))
                     && held_reg[rel_idx[lpr_pkg::SLOT_AW-1:0]];
    assign take    = cmp_valid_reg && both_reg[cmp_idx_reg]
                     && (!found_reg || (ram_rd_data < best_stamp_reg));

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        now_next        = now_reg;
        both_next       = both_reg;
        rel_next        = rel_reg;
        n_next          = n_reg;
        cnt_next        = cnt_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_stamp_next = best_stamp_reg;
        held_next       = held_reg;
        res_next        = res_reg;
        ram_req         = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next      = s_data.kind;
                    now_next       = s_data.now_time;
                    both_next      = s_data.local_free_mask & s_data.remote_free_mask;
                    rel_next       = s_data.release_port;
                    n_next         = n_sat;
                    cnt_next       = '0;
                    cmp_valid_next = 1'b0;
                    found_next     = 1'b0;
                    if (s_data.kind == lpr_pkg::KIND_RELEASE) begin
                        state_next = ST_REL;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (take) begin
                    found_next      = 1'b1;
                    best_next       = cmp_idx_reg;
                    best_stamp_next = ram_rd_data;
                end
                if (cnt_reg < n_reg) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = cnt_reg[lpr_pkg::SLOT_AW-1:0];
                    cnt_next        = cnt_reg + 1'b1;
                    cmp_valid_next  = 1'b1;
                    cmp_idx_next    = cnt_reg[lpr_pkg::SLOT_AW-1:0];
                end else begin
                    cmp_valid_next = 1'b0;
                    if (!cmp_valid_reg) begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_COMMIT: begin
                if (found_reg) begin
                    ram_req.wr_en       = 1'b1;
                    ram_req.wr_addr     = best_reg;
                    ram_req.wr_data     = now_reg;
                    held_next[best_reg] = 1'b1;
                    res_next.granted_port =
                        cfg.base_port + lpr_pkg::PORT_W'(best_reg);
                    res_next.status     = lpr_pkg::STATUS_OK;
                end else begin
                    res_next.granted_port = '0;
                    res_next.status       = lpr_pkg::STATUS_EXHAUSTED;
                end
                state_next = ST_FINISH;
            end
            ST_REL: begin
                if (rel_hit) begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = rel_idx[lpr_pkg::SLOT_AW-1:0];
                    ram_req.wr_data = '0;
                    held_next[rel_idx[lpr_pkg::SLOT_AW-1:0]] = 1'b0;
                end
                res_next.granted_port = '0;
                res_next.status       = lpr_pkg::STATUS_OK;
                state_next            = ST_FINISH;
            end
            ST_FINISH: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            cmp_valid_reg <= cmp_valid_next;
        end
        kind_reg       <= kind_next;
        now_reg        <= now_next;
        both_reg       <= both_next;
        rel_reg        <= rel_next;
        n_reg          <= n_next;
        cnt_reg        <= cnt_next;
        cmp_idx_reg    <= cmp_idx_next;
        found_reg      <= found_next;
        best_reg       <= best_next;
        best_stamp_reg <= best_stamp_next;
        res_reg        <= res_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FINISH);
    assign res_data  = res_reg;

    // scan reads and commit writes never share a cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_req.rd_en && ram_req.wr_en))
        else $error("stamp RAM read and write in the same cycle");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.rd_en |-> (lpr_pkg::CNT_W'(ram_req.rd_addr) < n_reg))
        else $error("scan read beyond active slot count");

    a_commit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_req.wr_en && state_reg == ST_COMMIT) |=> held_reg[$past(ram_req.wr_addr)])
        else $error("reserved slot not marked held");

    a_exhausted_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_data.status == lpr_pkg::STATUS_EXHAUSTED)
            |-> (res_data.granted_port == '0))
        else $error("exhausted result carries a port");

endmodule

`default_nettype wire

@@ rtl/core/lru_port_reserver.sv @@
// Top level of the LRU port reserver: APB register block, output register,
// and instances of lpr_scan_ctrl and lpr_stamp_ram. Uses lpr_pkg.
//
// A reserve request reads the stamps of the first n slots one per cycle through
// the single read port of the stamp RAM, where n is slot_count capped at 64.
// A reserve or a release cannot finish while the output register still holds
// a result that has not been taken.
// One request is in flight at a time; a finished result waits in the output
// register while the next request is accepted. The stamp store starts out all
// zero right after reset through per-slot valid bits, with no clearing pass.
// Registers: base_port at 0x0, slot_count at 0x4 (values above 64 act as 64).
`timescale 1ns / 1ps
`default_nettype none

module lru_port_reserver (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [lpr_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire lpr_pkg::lpr_req_t            s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output lpr_pkg::lpr_resp_t                m_data
);

    lpr_pkg::lpr_cfg_t            cfg_reg;
    lpr_pkg::lpr_ram_req_t        ram_req;
    logic [lpr_pkg::STAMP_W-1:0]  ram_rd_data;
    logic                         res_valid;
    logic                         res_ready;
    lpr_pkg::lpr_resp_t           res_data;
    logic                         m_valid_reg;
    lpr_pkg::lpr_resp_t           m_data_reg;
    logic                         apb_wr;

    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_port  <= '0;
            cfg_reg.slot_count <= lpr_pkg::CNT_REG_W'(lpr_pkg::MAX_SLOTS);
        end else if (apb_wr) begin
            case (paddr[2])
                lpr_pkg::REG_BASE_PORT: begin
                    cfg_reg.base_port <= pwdata[lpr_pkg::PORT_W-1:0];
                end
                lpr_pkg::REG_SLOT_COUNT: begin
                    cfg_reg.slot_count <= pwdata[lpr_pkg::CNT_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            lpr_pkg::REG_BASE_PORT:  prdata = 32'(cfg_reg.base_port);
            lpr_pkg::REG_SLOT_COUNT: prdata = 32'(cfg_reg.slot_count);
            default:                 prdata = '0;
        endcase
    end

    lpr_scan_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .res_valid   (res_valid),
        .res_data    (res_data),
        .res_ready   (res_ready)
    );

    lpr_stamp_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ tb/sv/port_ledger_pkg.sv @@
// Port ledger class: tracks slot stamps, held slots and the responses due.
// Depends on lpr_pkg from rtl/core for the request and response types.
`timescale 1ns / 1ps

package port_ledger_pkg;

    import lpr_pkg::*;

    class port_ledger;
        logic [PORT_W-1:0]    base_port;
        logic [CNT_REG_W-1:0] slot_count;
        logic [STAMP_W-1:0]   stamps [MAX_SLOTS];
        logic [MASK_W-1:0]    held;
        lpr_resp_t            responses_due [$];
        int unsigned          mismatches;

        function new();
            base_port  = '0;
            slot_count = CNT_REG_W'(MAX_SLOTS);
            foreach (stamps[i]) stamps[i] = '0;
            held        = '0;
            mismatches  = 0;
        endfunction

        function void set_register(logic reg_idx, logic [31:0] value);
            if (reg_idx == REG_BASE_PORT) begin
                base_port = value[PORT_W-1:0];
            end else begin
                slot_count = value[CNT_REG_W-1:0];
            end
        endfunction

        function int unsigned live_slots();
            return (slot_count > MAX_SLOTS) ? MAX_SLOTS : slot_count;
        endfunction

        function int unsigned pending();
            return responses_due.size();
        endfunction

        function void log_request(lpr_req_t req);
            logic [MASK_W-1:0] both;
            logic [PORT_W-1:0] slot_off;
            int unsigned       n;
            int                best;
            lpr_resp_t         due;
            n    = live_slots();
            both = req.local_free_mask & req.remote_free_mask;
            due.granted_port = '0;
            due.status       = STATUS_OK;
            if (req.kind == KIND_RESERVE) begin
                best = -1;
                for (int i = 0; i < n; i++) begin
                    if (both[i] && (best < 0 || stamps[i] < stamps[best])) best = i;
                end
                if (best >= 0) begin
                    stamps[best]     = req.now_time;
                    held[best]       = 1'b1;
                    due.granted_port = base_port + PORT_W'(best);
                end else begin
                    due.status = STATUS_EXHAUSTED;
                end
            end else begin
                slot_off = req.release_port - base_port;
                if (slot_off < n && held[slot_off[SLOT_AW-1:0]]) begin
                    stamps[slot_off[SLOT_AW-1:0]] = '0;
                    held[slot_off[SLOT_AW-1:0]]   = 1'b0;
                end
            end
            responses_due.insert(responses_due.size(), due);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_response(lpr_resp_t got);
            lpr_resp_t want;
            if (responses_due.size() == 0) begin
                report($sformatf("response with none due: port %0d status %0d",
                                 got.granted_port, got.status));
                return;
            end
            want = responses_due.pop_front();
            if (got.granted_port !== want.granted_port) begin
                report($sformatf("granted_port %0d, want %0d",
                                 got.granted_port, want.granted_port));
            end
            if (got.status !== want.status) begin
                report($sformatf("status %0d, want %0d", got.status, want.status));
            end
        endtask
    endclass

endpackage

@@ tb/sv/lru_port_reserver_test.sv @@
// Top-level test of lru_port_reserver: directed and random requests under
// varying backpressure, checked against port_ledger. Uses lpr_pkg, port_ledger_pkg.
`timescale 1ns / 1ps

module lru_port_reserver_test;

    import lpr_pkg::*;
    import port_ledger_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 50;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    lpr_req_t            s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    lpr_resp_t           m_data;

    int unsigned send_idle_pct = 19;
    int unsigned recv_idle_pct = 61;
    int unsigned quiet_cycles  = 0;
    int unsigned items_sent    = 0;
    port_ledger  ledger;

    lru_port_reserver dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) ledger.log_request(s_data);
            if (m_valid && m_ready) ledger.check_response(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("Regression FAIL");
        $finish;
    end

    task apb_write(logic reg_idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        ledger.set_register(reg_idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task send_request(lpr_req_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (ledger.pending() != 0) @(posedge aclk);
    endtask

    task configure_slots(logic [PORT_W-1:0] base, logic [CNT_REG_W-1:0] count);
        wait_drained();
        apb_write(REG_BASE_PORT, 32'(base));
        apb_write(REG_SLOT_COUNT, 32'(count));
    endtask

    function automatic lpr_req_t make_reserve(logic [STAMP_W-1:0] t,
                                              logic [MASK_W-1:0] lm,
                                              logic [MASK_W-1:0] rm);
        lpr_req_t r;
        r.kind             = KIND_RESERVE;
        r.now_time         = t;
        r.local_free_mask  = lm;
        r.remote_free_mask = rm;
        r.release_port     = PORT_W'($urandom);
        return r;
    endfunction

    function automatic lpr_req_t make_release(logic [PORT_W-1:0] port);
        lpr_req_t r;
        r.kind             = KIND_RELEASE;
        r.now_time         = $urandom;
        r.local_free_mask  = {$urandom, $urandom};
        r.remote_free_mask = {$urandom, $urandom};
        r.release_port     = port;
        return r;
    endfunction

    function automatic logic [MASK_W-1:0] random_mask();
        case ($urandom_range(5))
            0: return '1;
            1: return {$urandom, $urandom};
            2: return {$urandom, $urandom} | {$urandom, $urandom};
            3: return 64'b1 << $urandom_range(63);
            4: return ~(64'b1 << $urandom_range(63));
            default: return {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [STAMP_W-1:0] random_stamp();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2, 3: return STAMP_W'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    function automatic lpr_req_t random_request();
        int unsigned n;
        n = ledger.live_slots();
        if ($urandom_range(9) < 6) begin
            return make_reserve(random_stamp(), random_mask(), random_mask());
        end
        if (n != 0 && $urandom_range(9) < 7) begin
            return make_release(ledger.base_port + PORT_W'($urandom_range(n - 1)));
        end
        return make_release(PORT_W'($urandom));
    endfunction

    initial begin
        logic [PORT_W-1:0]    base;
        logic [CNT_REG_W-1:0] count;
        ledger = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: ties, zero time, held re-reserve, wrap, range and count edges
        configure_slots(16'd0, 7'd64);
        send_request(make_reserve(32'd0, '1, '1));
        send_request(make_reserve(32'd5, '1, '1));
        send_request(make_reserve(32'd7, '1, '1));
        send_request(make_reserve('1, '1, 64'h8000_0000_0000_0000));
        send_request(make_reserve(32'd9, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
        send_request(make_reserve(32'd9, '0, '0));
        send_request(make_reserve(32'd11, 64'h1, '1));
        send_request(make_release(16'd63));
        send_request(make_release(16'd63));
        send_request(make_release(16'd64));
        send_request(make_release(16'hFFFF));
        configure_slots(16'hFFFF, 7'd127);
        send_request(make_reserve(32'd20, 64'h2, '1));
        send_request(make_reserve(32'd21, '1, 64'h8000_0000_0000_0000));
        send_request(make_release(16'd0));
        send_request(make_release(16'hFFFE));
        configure_slots(16'hFFFF, 7'd0);
        send_request(make_reserve(32'd30, '1, '1));
        send_request(make_release(16'hFFFF));
        configure_slots(16'd0, 7'd1);
        send_request(make_reserve(32'd40, 64'h2, '1));
        send_request(make_reserve(32'd41, '1, '1));

        items_sent = 0;
        for (int p = 0; p < PHASES; p++) begin
            case (p % 6)
                0: count = 7'd64;
                1: count = 7'd1;
                2: count = 7'd127;
                3: count = 7'd0;
                4: count = CNT_REG_W'($urandom_range(2, 8));
                default: count = CNT_REG_W'($urandom_range(1, 64));
            endcase
            case (p % 4)
                0: base = 16'd0;
                1: base = 16'hFFFF;
                2: base = 16'hFFC0 + PORT_W'($urandom_range(63));
                default: base = PORT_W'($urandom);
            endcase
            configure_slots(base, count);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (items_sent == 200) begin
                    send_idle_pct = 61;
                    recv_idle_pct = 19;
                end else if (items_sent == 400) begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                if (p == 5 && k == PHASE_ITEMS / 2) wait_drained();
                send_request(random_request());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (ledger.pending() != 0) ledger.report("responses still outstanding");
        if (ledger.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
